// ===== rtl/ige_pkg.sv =====
// Shared types and constants for the implication graph engine.
`default_nettype none

package ige_pkg;

  localparam int unsigned VarW = 8;
  localparam int unsigned LitW = VarW + 1;

  typedef enum logic [1:0] {
    CMD_ADD_VERTEX = 2'd0,
    CMD_ADD_EDGE   = 2'd1,
    CMD_QUERY      = 2'd2,
    CMD_PRUNE      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_CLOSE,
    S_LOAD,
    S_EMIT,
    S_APPLY,
    S_SINGLE
  } state_e;

  typedef struct packed {
    cmd_e            command;
    logic [VarW-1:0] var_a;
    logic            neg_a;
    logic [VarW-1:0] var_b;
    logic            neg_b;
    logic            clause_end;
  } in_item_t;

  typedef struct packed {
    logic [VarW-1:0] out_var;
    logic            out_neg;
    logic            has_item;
    status_e         status;
    logic            last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    lookup;
    logic    insert;
    logic    ins_sel_b;
    logic    link_edge;
    logic    seed;
    logic    close_step;
    logic    load_emit;
    logic    emit_item;
    logic    emit_single;
    status_e single_status;
    logic    apply_prune;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e command;
    logic clause_end;
    logic hit_a;
    logic hit_b;
    logic has_free;
    logic changed;
    logic emit_empty;
    logic emit_one;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/ige_datapath.sv =====
// Datapath: slot table, edge matrix, closure vectors, emit sweep and output register.
`default_nettype none

module ige_datapath #(
  parameter int unsigned SLOTS     = 32,
  parameter int unsigned VAR_COUNT = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ige_pkg::in_item_t  in_item_i,
  input  wire ige_pkg::ctrl_cmd_t cmd_i,
  output ige_pkg::dp_status_t     status_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ige_pkg::out_item_t      out_item_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LW = ige_pkg::LitW;
  localparam int unsigned VW = ige_pkg::VarW;

  // Captured transaction.
  ige_pkg::cmd_e cmd_q;
  logic          end_q;
  logic [LW-1:0] lit_a_q, lit_b_q;
  logic [VW-1:0] var_a_red, var_b_red;

  // Slot table and graph.
  logic             used_q [SLOTS];
  logic             used_d [SLOTS];
  logic [LW-1:0]    lit_q  [SLOTS];
  logic [SLOTS-1:0] row_q  [SLOTS];
  logic [SLOTS-1:0] row_d  [SLOTS];
  logic [SLOTS-1:0] visit_q, gone_q, emit_q;
  logic [SLOTS-1:0] visit_step, gone_step, incoming, roots;

  // Lookup results.
  logic [LW-1:0]    key_a;
  logic [SLOTS-1:0] match_a, match_b, free_v;
  logic [IW-1:0]    ia, ib, ifr;
  logic [IW-1:0]    ka_q, kb_q, kf_q, child;
  logic             hit_a_q, hit_b_q, free_q;
  logic [IW-1:0]    emit_idx;

  // Output register.
  logic             out_valid_q;
  ige_pkg::out_item_t out_q;

  // Variable indexes reduced modulo the variable count by shifted subtraction.
  always_comb begin
    logic [31:0] ra, rb;
    ra = 32'(in_item_i.var_a);
    rb = 32'(in_item_i.var_b);
    for (int k = VW - 1; k >= 0; k--) begin
      if (ra >= (32'(VAR_COUNT) << k)) ra = ra - (32'(VAR_COUNT) << k);
      if (rb >= (32'(VAR_COUNT) << k)) rb = rb - (32'(VAR_COUNT) << k);
    end
    var_a_red = ra[VW-1:0];
    var_b_red = rb[VW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= in_item_i.command;
      end_q   <= in_item_i.clause_end;
      lit_a_q <= {var_a_red, in_item_i.neg_a};
      lit_b_q <= {var_b_red, in_item_i.neg_b};
    end
  end

  // A query looks for the negation of its literal.
  assign key_a = (cmd_q == ige_pkg::CMD_QUERY) ? (lit_a_q ^ LW'(1)) : lit_a_q;

  // Parallel compare against every used slot, then lowest-index selection.
  always_comb begin
    ia  = '0;
    ib  = '0;
    ifr = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match_a[i] = used_q[i] && (lit_q[i] == key_a);
      match_b[i] = used_q[i] && (lit_q[i] == lit_b_q);
      free_v[i]  = !used_q[i];
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_a[i]) ia = IW'(i);
      if (match_b[i]) ib = IW'(i);
      if (free_v[i])  ifr = IW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      ka_q    <= ia;
      kb_q    <= ib;
      kf_q    <= ifr;
      hit_a_q <= |match_a;
      hit_b_q <= |match_b;
      free_q  <= |free_v;
    end
  end

  assign child = hit_b_q ? kb_q : kf_q;

  // One closure iteration: ancestors for a query, descendants for a prune.
  always_comb begin
    gone_step = gone_q;
    for (int p = 0; p < SLOTS; p++) begin
      visit_step[p] = visit_q[p] | (used_q[p] && |(row_q[p] & visit_q));
      if (used_q[p] && gone_q[p]) gone_step = gone_step | row_q[p];
    end
  end

  // Roots among the gathered ancestors: used slots with no used parent.
  always_comb begin
    incoming = '0;
    for (int p = 0; p < SLOTS; p++) begin
      if (used_q[p]) incoming = incoming | row_q[p];
    end
    for (int i = 0; i < SLOTS; i++) begin
      roots[i] = used_q[i] && visit_q[i] && !incoming[i];
    end
  end

  // Table and matrix updates.
  always_comb begin
    for (int r = 0; r < SLOTS; r++) begin
      used_d[r] = used_q[r];
      row_d[r]  = row_q[r];
    end
    if (cmd_i.insert) begin
      used_d[kf_q] = 1'b1;
      for (int r = 0; r < SLOTS; r++) begin
        row_d[r][kf_q] = 1'b0;
      end
      row_d[kf_q] = '0;
    end
    if (cmd_i.link_edge) begin
      row_d[ka_q][child] = 1'b1;
    end
    if (cmd_i.apply_prune) begin
      for (int r = 0; r < SLOTS; r++) begin
        if (gone_q[r]) begin
          used_d[r] = 1'b0;
          row_d[r]  = '0;
        end else begin
          row_d[r] = row_q[r] & ~gone_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < SLOTS; r++) begin
        used_q[r] <= 1'b0;
        row_q[r]  <= '0;
      end
      visit_q <= '0;
    end else begin
      for (int r = 0; r < SLOTS; r++) begin
        used_q[r] <= used_d[r];
        row_q[r]  <= row_d[r];
      end
      if (cmd_i.seed && (cmd_q == ige_pkg::CMD_QUERY)) begin
        visit_q[ka_q] <= 1'b1;
      end else if (cmd_i.close_step && (cmd_q == ige_pkg::CMD_QUERY)) begin
        visit_q <= visit_step;
      end else if (cmd_i.load_emit && (cmd_q == ige_pkg::CMD_QUERY)) begin
        visit_q <= '0;
      end
    end
  end

  // Literal store, written only on insert.
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      lit_q[kf_q] <= cmd_i.ins_sel_b ? lit_b_q : lit_a_q;
    end
  end

  // Prune set and emit vector.
  always_ff @(posedge clk_i) begin
    if (cmd_i.seed) begin
      gone_q <= SLOTS'(1) << ka_q;
    end else if (cmd_i.close_step) begin
      gone_q <= gone_step;
    end
    if (cmd_i.load_emit) begin
      emit_q <= (cmd_q == ige_pkg::CMD_QUERY) ? roots : gone_q;
    end else if (cmd_i.emit_item) begin
      emit_q[emit_idx] <= 1'b0;
    end
  end

  always_comb begin
    emit_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (emit_q[i]) emit_idx = IW'(i);
    end
  end

  // Output register; a new result loads only when the slot is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_item || cmd_i.emit_single) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_item) begin
      out_q.out_var  <= lit_q[emit_idx][LW-1:1];
      out_q.out_neg  <= (cmd_q == ige_pkg::CMD_QUERY) ? ~lit_q[emit_idx][0] : 1'b0;
      out_q.has_item <= 1'b1;
      out_q.status   <= ige_pkg::ST_OK;
      out_q.last     <= status_o.emit_one;
    end else if (cmd_i.emit_single) begin
      out_q.out_var  <= '0;
      out_q.out_neg  <= 1'b0;
      out_q.has_item <= 1'b0;
      out_q.status   <= cmd_i.single_status;
      out_q.last     <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Status back to the controller.
  always_comb begin
    status_o.command    = cmd_q;
    status_o.clause_end = end_q;
    status_o.hit_a      = hit_a_q;
    status_o.hit_b      = hit_b_q;
    status_o.has_free   = free_q;
    status_o.changed    = (cmd_q == ige_pkg::CMD_QUERY) ? (visit_step != visit_q)
                                                          : (gone_step != gone_q);
    status_o.emit_empty = (emit_q == '0);
    status_o.emit_one   = (emit_q != '0) && ((emit_q & (emit_q - SLOTS'(1))) == '0);
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

`default_nettype wire

// ===== rtl/ige_ctrl.sv =====
// Controller state machine that sequences lookup, closure and result emission.
`default_nettype none

module ige_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ige_pkg::dp_status_t status_i,
  output ige_pkg::ctrl_cmd_t       cmd_o
);

  ige_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ige_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ige_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ige_pkg::S_LOOKUP;
      end
      ige_pkg::S_LOOKUP: state_d = ige_pkg::S_DECIDE;
      ige_pkg::S_DECIDE: begin
        unique case (status_i.command)
          ige_pkg::CMD_QUERY: begin
            if (status_i.hit_a)          state_d = ige_pkg::S_CLOSE;
            else if (status_i.clause_end) state_d = ige_pkg::S_LOAD;
            else                         state_d = ige_pkg::S_SINGLE;
          end
          ige_pkg::CMD_PRUNE: begin
            state_d = status_i.hit_a ? ige_pkg::S_CLOSE : ige_pkg::S_SINGLE;
          end
          default: state_d = ige_pkg::S_SINGLE;
        endcase
      end
      ige_pkg::S_CLOSE: begin
        if (!status_i.changed) begin
          if (status_i.command == ige_pkg::CMD_QUERY && !status_i.clause_end) begin
            state_d = ige_pkg::S_SINGLE;
          end else begin
            state_d = ige_pkg::S_LOAD;
          end
        end
      end
      ige_pkg::S_LOAD: state_d = ige_pkg::S_EMIT;
      ige_pkg::S_EMIT: begin
        if (status_i.out_free) begin
          if (status_i.emit_empty) begin
            state_d = ige_pkg::S_IDLE;
          end else if (status_i.emit_one) begin
            state_d = (status_i.command == ige_pkg::CMD_PRUNE) ? ige_pkg::S_APPLY
                                                                : ige_pkg::S_IDLE;
          end
        end
      end
      ige_pkg::S_APPLY: state_d = ige_pkg::S_IDLE;
      ige_pkg::S_SINGLE: begin
        if (status_i.out_free) state_d = ige_pkg::S_IDLE;
      end
      default: state_d = ige_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o               = '0;
    cmd_o.single_status = ige_pkg::ST_OK;
    in_stall_o          = (state_q != ige_pkg::S_IDLE);
    unique case (state_q)
      ige_pkg::S_IDLE:   cmd_o.capture = in_valid_i;
      ige_pkg::S_LOOKUP: cmd_o.lookup = 1'b1;
      ige_pkg::S_DECIDE: begin
        unique case (status_i.command)
          ige_pkg::CMD_ADD_VERTEX: begin
            cmd_o.insert = !status_i.hit_a && status_i.has_free;
          end
          ige_pkg::CMD_ADD_EDGE: begin
            if (status_i.hit_a) begin
              if (status_i.hit_b) begin
                cmd_o.link_edge = 1'b1;
              end else if (status_i.has_free) begin
                cmd_o.insert    = 1'b1;
                cmd_o.ins_sel_b = 1'b1;
                cmd_o.link_edge = 1'b1;
              end
            end
          end
          default: cmd_o.seed = status_i.hit_a;
        endcase
      end
      ige_pkg::S_CLOSE: cmd_o.close_step = 1'b1;
      ige_pkg::S_LOAD:  cmd_o.load_emit = 1'b1;
      ige_pkg::S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_single = status_i.emit_empty;
          cmd_o.emit_item   = !status_i.emit_empty;
        end
      end
      ige_pkg::S_APPLY: cmd_o.apply_prune = 1'b1;
      ige_pkg::S_SINGLE: begin
        cmd_o.emit_single = status_i.out_free;
        if ((status_i.command == ige_pkg::CMD_ADD_VERTEX && !status_i.hit_a &&
             !status_i.has_free) ||
            (status_i.command == ige_pkg::CMD_ADD_EDGE && status_i.hit_a &&
             !status_i.hit_b && !status_i.has_free)) begin
          cmd_o.single_status = ige_pkg::ST_FULL;
        end else if (status_i.command == ige_pkg::CMD_PRUNE && !status_i.hit_a) begin
          cmd_o.single_status = ige_pkg::ST_ABSENT;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/implication_graph_engine.sv =====
// Top level of the implication graph engine: controller, datapath and checks.
//
// Usage: commands arrive on the input channel (in_valid_i, in_stall_o,
// in_item_i); results leave on the output channel (out_valid_o, out_stall_i,
// out_item_o). A transaction completes when valid is high and stall is low.
// Every command yields at least one result; the final one has last set.
// One command is processed at a time: in_stall_o is high from acceptance
// until the command's last result has been loaded into the output register
// and, for a prune, the removal has been applied. Add vertex and add edge
// pass through lookup and decide, then load their single result once the
// output register is free. A query literal that is found runs closure
// iterations over the edge matrix (at most SLOTS, the last one finding no
// change); at clause end the roots then pass through a load state into the
// emit sweep, which loads one root per cycle while the output register is
// free. Prune runs the same closure, loads its removed slots through the
// emit sweep in the same way, and then applies the removal in a final state.
// Reset clears the slot table, the edge matrix and the query marks at once.
// When the receiver stalls, the output register holds its result and the
// emit sweep waits; the input stays stalled until the command completes.
`default_nettype none

module implication_graph_engine #(
  parameter int unsigned SLOTS     = 32,
  parameter int unsigned VAR_COUNT = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ige_pkg::in_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ige_pkg::out_item_t     out_item_o
);

  ige_pkg::ctrl_cmd_t  ctrl_cmd;
  ige_pkg::dp_status_t dp_status;

  ige_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  ige_datapath #(
    .SLOTS     (SLOTS),
    .VAR_COUNT (VAR_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // An accepted transaction blocks the input on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not blocked after acceptance");

  // An empty result always closes its command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.has_item |-> out_item_o.last)
    else $error("empty result without last");

  // Error status only on a single empty result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ige_pkg::ST_OK |->
      !out_item_o.has_item && out_item_o.last)
    else $error("error status on a data result");

endmodule

`default_nettype wire
